// ===== rtl/ucd_pkg.sv =====
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; used by every module of the decoder.
package ucd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CpW        = 21;

  localparam logic [CpW-1:0] CpMinTwo   = 21'h00080;
  localparam logic [CpW-1:0] CpMinThree = 21'h00800;
  localparam logic [CpW-1:0] CpMinFour  = 21'h10000;
  localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo     = 21'h0D800;
  localparam logic [CpW-1:0] SurrHi     = 21'h0DFFF;

  // class of a byte when it opens a text
  typedef enum logic [2:0] {
    LEAD_ZERO,
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_e;

  // classified request as it travels from front to back
  typedef struct packed {
    logic       has_byte;
    logic       last;
    lead_e      lead;
    logic [6:0] lead_val;
    logic       cont_ok;
    logic [5:0] cont_val;
  } item_t;

endpackage

// ===== rtl/ucd_front.sv =====
// Front end: takes input requests, classifies the byte and pushes it to the queue.
// Depends on ucd_pkg.
module ucd_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      text_byte_i,
  input  logic            last_byte_i,
  input  logic            empty_text_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ucd_pkg::item_t  item_o
);

  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // an empty step without the last flag does nothing; drop it here
  assign push_o     = accept && !(empty_text_i && !last_byte_i);

  always_comb begin
    item_o          = '0;
    item_o.has_byte = !empty_text_i;
    item_o.last     = last_byte_i;
    item_o.cont_ok  = (text_byte_i[7:6] == 2'b10);
    item_o.cont_val = text_byte_i[5:0];
    item_o.lead     = ucd_pkg::LEAD_BAD;
    item_o.lead_val = '0;
    case (1'b1)
      (text_byte_i == 8'h00): begin
        item_o.lead = ucd_pkg::LEAD_ZERO;
      end
      (text_byte_i[7] == 1'b0): begin
        item_o.lead     = ucd_pkg::LEAD_ASCII;
        item_o.lead_val = text_byte_i[6:0];
      end
      (text_byte_i[7:5] == 3'b110): begin
        item_o.lead     = ucd_pkg::LEAD_TWO;
        item_o.lead_val = {2'b00, text_byte_i[4:0]};
      end
      (text_byte_i[7:4] == 4'b1110): begin
        item_o.lead     = ucd_pkg::LEAD_THREE;
        item_o.lead_val = {3'b000, text_byte_i[3:0]};
      end
      (text_byte_i[7:3] == 5'b11110): begin
        item_o.lead     = ucd_pkg::LEAD_FOUR;
        item_o.lead_val = {4'b0000, text_byte_i[2:0]};
      end
      default: begin
        item_o.lead = ucd_pkg::LEAD_BAD;
      end
    endcase
  end

endmodule

// ===== rtl/ucd_queue.sv =====
// Short register queue between front and back of the decoder.
// Depends on ucd_pkg.
module ucd_queue #(
  parameter int unsigned Depth = ucd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ucd_pkg::item_t  item_i,
  input  logic            pop_i,
  output ucd_pkg::item_t  head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ucd_pkg::item_t        slot_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/ucd_back.sv =====
// Back end: assembles the code point from queued bytes, validates, and
// holds the result in an output register. Depends on ucd_pkg.
module ucd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ucd_pkg::item_t            head_i,
  input  logic                      q_empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      decode_ok_o,
  output logic [ucd_pkg::CpW-1:0]   code_point_o
);

  logic                    inside_q, inside_d;
  logic                    ascii_q, ascii_d;
  logic                    err_q, err_d;
  logic [1:0]              exp_q, exp_d;
  logic [2:0]              rcv_q, rcv_d;
  logic [ucd_pkg::CpW-1:0] pv_q, pv_d;

  logic                    out_valid_q, out_valid_d;
  logic                    ok_q, ok_d;
  logic [ucd_pkg::CpW-1:0] cp_q, cp_d;

  logic                    out_free;
  logic                    fin_ok;
  logic                    long_ok;
  logic                    load_out;

  assign out_free = !out_valid_q || !out_stall_i;
  // a last byte needs room in the output register; other bytes never wait
  assign pop_o    = !q_empty_i && (!head_i.last || out_free);
  assign load_out = pop_o && head_i.last;

  // state after taking the head byte
  always_comb begin
    inside_d = inside_q;
    ascii_d  = ascii_q;
    err_d    = err_q;
    exp_d    = exp_q;
    rcv_d    = rcv_q;
    pv_d     = pv_q;
    if (head_i.has_byte) begin
      if (!inside_q) begin
        inside_d = 1'b1;
        case (head_i.lead)
          ucd_pkg::LEAD_ASCII: begin
            ascii_d = 1'b1;
            pv_d    = ucd_pkg::CpW'(head_i.lead_val);
          end
          ucd_pkg::LEAD_TWO: begin
            exp_d = 2'd1;
            pv_d  = ucd_pkg::CpW'(head_i.lead_val);
          end
          ucd_pkg::LEAD_THREE: begin
            exp_d = 2'd2;
            pv_d  = ucd_pkg::CpW'(head_i.lead_val);
          end
          ucd_pkg::LEAD_FOUR: begin
            exp_d = 2'd3;
            pv_d  = ucd_pkg::CpW'(head_i.lead_val);
          end
          default: begin
            err_d = 1'b1;
          end
        endcase
      end else if (!ascii_q && !err_q) begin
        rcv_d = (rcv_q == 3'd4) ? rcv_q : rcv_q + 3'd1;
        if (rcv_d <= {1'b0, exp_q}) begin
          if (!head_i.cont_ok) begin
            err_d = 1'b1;
          end else begin
            pv_d = {pv_q[ucd_pkg::CpW-7:0], head_i.cont_val};
          end
        end
      end
    end
  end

  // shortest-form check per sequence length
  always_comb begin
    case (exp_d)
      2'd1:    long_ok = (pv_d >= ucd_pkg::CpMinTwo);
      2'd2:    long_ok = (pv_d >= ucd_pkg::CpMinThree);
      2'd3:    long_ok = (pv_d >= ucd_pkg::CpMinFour);
      default: long_ok = 1'b0;
    endcase
  end

  assign fin_ok = inside_d && !err_d &&
                  (ascii_d ||
                   ((rcv_d == {1'b0, exp_d}) && long_ok &&
                    (pv_d <= ucd_pkg::CpMax) &&
                    !((pv_d >= ucd_pkg::SurrLo) && (pv_d <= ucd_pkg::SurrHi))));

  always_comb begin
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    cp_d        = cp_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      ok_d        = fin_ok;
      cp_d        = fin_ok ? pv_d : '0;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q    <= 1'b0;
      ascii_q     <= 1'b0;
      err_q       <= 1'b0;
      exp_q       <= '0;
      rcv_q       <= '0;
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load_out) begin
        inside_q <= 1'b0;
        ascii_q  <= 1'b0;
        err_q    <= 1'b0;
        exp_q    <= '0;
        rcv_q    <= '0;
        pv_q     <= '0;
      end else if (pop_o) begin
        inside_q <= inside_d;
        ascii_q  <= ascii_d;
        err_q    <= err_d;
        exp_q    <= exp_d;
        rcv_q    <= rcv_d;
        pv_q     <= pv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q <= ok_d;
    cp_q <= cp_d;
  end

  assign out_valid_o  = out_valid_q;
  assign decode_ok_o  = ok_q;
  assign code_point_o = cp_q;

endmodule

// ===== rtl/utf8_code_point_decoder.sv =====
// Top level of the UTF-8 code point decoder: front classifier, queue, back end.
// Depends on ucd_pkg, ucd_front, ucd_queue and ucd_back.
//
// Usage:
//  - Input channel: one request per text byte (text_byte_i), with last_byte_i
//    on the final one. empty_text_i with last_byte_i ends the text without a
//    byte; empty_text_i alone is taken and dropped.
//  - Output channel: one request per text, on its last byte: decode_ok_o and
//    code_point_o (zero on failure).
//  - Both channels: request moves when valid is high and stall is low.
//  - Path: a last byte taken on the input passes through the queue, then
//    the back end's output register, before its result shows.
//  - Throughput: one byte per cycle sustained without receiver stall; the
//    queue plus the output register let both sides keep moving at full rate.
//  - Receiver stall: the result holds in the output register; non-final
//    bytes keep draining from the queue, and input stall rises only when
//    the QueueDepth-entry queue fills behind a waiting final byte.
//  - Reset: queue empty, no result pending, decode state cleared.
module utf8_code_point_decoder #(
  parameter int unsigned QueueDepth = ucd_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                text_byte_i,
  input  logic                      last_byte_i,
  input  logic                      empty_text_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      decode_ok_o,
  output logic [ucd_pkg::CpW-1:0]   code_point_o
);

  ucd_pkg::item_t push_item;
  ucd_pkg::item_t head_item;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;

  // classify incoming bytes; only meaningful requests enter the queue
  ucd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .last_byte_i  (last_byte_i),
    .empty_text_i (empty_text_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  // decouples the classifier from the output stall
  ucd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // decode state machine and output register
  ucd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .q_empty_i    (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .decode_ok_o  (decode_ok_o),
    .code_point_o (code_point_o)
  );

  // failure always reports a zero code point
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !decode_ok_o) |-> (code_point_o == '0))
    else $error("failed decode with nonzero code point");

  // success is always a Unicode scalar value
  a_ok_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && decode_ok_o) |->
      ((code_point_o <= ucd_pkg::CpMax) &&
       !((code_point_o >= ucd_pkg::SurrLo) && (code_point_o <= ucd_pkg::SurrHi))))
    else $error("successful decode outside scalar range");

  // a successful decode never yields NUL
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && decode_ok_o) |-> (code_point_o != '0))
    else $error("successful decode of zero");

  // the queue never overflows nor underflows
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full) && !(pop && q_empty))
    else $error("queue overflow or underflow");

endmodule

// ===== dv/tb_utf8_code_point_decoder.sv =====
// Self-checking testbench for utf8_code_point_decoder: directed and random byte texts,
// random idling on both channels, a scoreboard class predicts each decode result.
// Depends on ucd_pkg (lead_e, CpW, code point limits) and the decoder RTL.
module tb_utf8_code_point_decoder;

  localparam int unsigned NumItems   = 1500;
  localparam int unsigned PhaseLen   = 300;
  // Worst case per request: the longest idle gap on the sender, the longest
  // receiver stall, plus pipeline; several times over for ~1500 requests.
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainLimit = 4000;
  localparam int unsigned TailCycles = 12;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic                    ok;
    logic [ucd_pkg::CpW-1:0] cp;
  } verdict_t;

  // Scoreboard: mirrors the decode state per accepted request and queues
  // one expected verdict per text end.
  class Utf8Scoreboard;
    verdict_t                expected_q[$];
    int unsigned             errors = 0;

    bit                      in_text;
    bit                      ascii_ok;
    bit                      bad_seen;
    logic [1:0]              tails_wanted;
    logic [2:0]              tails_seen;
    logic [ucd_pkg::CpW-1:0] value;

    function ucd_pkg::lead_e classify(logic [7:0] b);
      if (b == 8'h00)               return ucd_pkg::LEAD_ZERO;
      if (!b[7])                    return ucd_pkg::LEAD_ASCII;
      if (b[7:5] == 3'b110)         return ucd_pkg::LEAD_TWO;
      if (b[7:4] == 4'b1110)        return ucd_pkg::LEAD_THREE;
      if (b[7:3] == 5'b11110)       return ucd_pkg::LEAD_FOUR;
      return ucd_pkg::LEAD_BAD;     // stray continuation or 0xF8..0xFF
    endfunction

    function void open_text(logic [7:0] b);
      in_text = 1'b1;
      case (classify(b))
        ucd_pkg::LEAD_ZERO:  bad_seen = 1'b1;
        ucd_pkg::LEAD_ASCII: begin
          ascii_ok = 1'b1;
          value    = ucd_pkg::CpW'(b);
        end
        ucd_pkg::LEAD_TWO: begin
          tails_wanted = 2'd1;
          value        = ucd_pkg::CpW'(b[4:0]);
        end
        ucd_pkg::LEAD_THREE: begin
          tails_wanted = 2'd2;
          value        = ucd_pkg::CpW'(b[3:0]);
        end
        ucd_pkg::LEAD_FOUR: begin
          tails_wanted = 2'd3;
          value        = ucd_pkg::CpW'(b[2:0]);
        end
        default:    bad_seen = 1'b1;
      endcase
    endfunction

    function void add_tail(logic [7:0] b);
      if (ascii_ok || bad_seen) return;
      if (tails_seen < 3'd4) tails_seen++;
      if (tails_seen <= {1'b0, tails_wanted}) begin
        if (b[7:6] != 2'b10) bad_seen = 1'b1;
        else value = {value[ucd_pkg::CpW-7:0], b[5:0]};
      end
    endfunction

    function verdict_t close_text();
      verdict_t v;
      v.ok = 1'b0;
      v.cp = '0;
      if (!in_text || bad_seen) return v;
      if (!ascii_ok) begin
        if (tails_seen != {1'b0, tails_wanted}) return v;
        // overlong forms
        if (tails_wanted == 2'd1 && value < ucd_pkg::CpMinTwo)   return v;
        if (tails_wanted == 2'd2 && value < ucd_pkg::CpMinThree) return v;
        if (tails_wanted == 2'd3 && value < ucd_pkg::CpMinFour)  return v;
        if (value > ucd_pkg::CpMax)                              return v;
        if (value >= ucd_pkg::SurrLo && value <= ucd_pkg::SurrHi) return v;
      end
      v.ok = 1'b1;
      v.cp = value;
      return v;
    endfunction

    function void note_request(logic [7:0] b, logic last, logic empty);
      if (!empty) begin
        if (!in_text) open_text(b);
        else add_tail(b);
      end
      if (last) begin
        expected_q.push_back(close_text());
        in_text      = 1'b0;
        ascii_ok     = 1'b0;
        bad_seen     = 1'b0;
        tails_wanted = '0;
        tails_seen   = '0;
        value        = '0;
      end
    endfunction

    function void check_result(logic ok, logic [ucd_pkg::CpW-1:0] cp);
      verdict_t exp_v;
      if (expected_q.size() == 0) begin
        $display("%0t: result ok=%0b cp=%06h with no text pending", $time, ok, cp);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      if (ok !== exp_v.ok) begin
        $display("%0t: decode_ok expected %0b actual %0b", $time, exp_v.ok, ok);
        errors++;
      end
      if (cp !== exp_v.cp) begin
        $display("%0t: code_point expected %06h actual %06h", $time, exp_v.cp, cp);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              text_byte_i  = 8'h00;
  logic                    last_byte_i  = 1'b0;
  logic                    empty_text_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic                    decode_ok_o;
  logic [ucd_pkg::CpW-1:0] code_point_o;

  Utf8Scoreboard  sb;

  // idling controls, switched per phase of the random run
  bit             gap_on   = 1'b0;
  bit             stall_on = 1'b0;
  int unsigned    stall_left;
  int unsigned    items_sent;
  int unsigned    cycles;

  // snapshot of the output channel just before each rising edge
  logic                    mon_valid;
  logic                    mon_stall;
  logic                    mon_ok;
  logic [ucd_pkg::CpW-1:0] mon_cp;

  utf8_code_point_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .last_byte_i  (last_byte_i),
    .empty_text_i (empty_text_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .decode_ok_o  (decode_ok_o),
    .code_point_o (code_point_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run guard: a hung handshake or a missing result ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver stall: mostly short bursts, a few long ones; off in some phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (stall_left == 0 && stall_on && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Outputs only move at rising edges, so the falling edge sees the values
  // that the next rising edge will act on.
  always @(negedge clk_i) begin
    mon_valid = out_valid_o;
    mon_stall = out_stall_i;
    mon_ok    = decode_ok_o;
    mon_cp    = code_point_o;
  end

  always @(posedge clk_i) begin
    if (rst_ni && mon_valid === 1'b1 && !mon_stall) sb.check_result(mon_ok, mon_cp);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gap_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One request on the input channel. Valid stays high after acceptance so
  // back-to-back requests keep full rate; a gap lowers it first.
  task automatic send_req(logic [7:0] b, logic last, logic empty);
    int unsigned gap;
    logic        stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    last_byte_i  <= last;
    empty_text_i <= empty;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    sb.note_request(b, last, empty);
    if (last || !empty) items_sent++;
  endtask

  // Sends one text. end_empty closes it with an empty request carrying the
  // last flag; sprinkle slips ignored empty requests in between bytes.
  task automatic send_text(octet_q_t txt, bit end_empty, bit sprinkle);
    for (int i = 0; i < txt.size(); i++) begin
      if (sprinkle && $urandom_range(0, 9) == 0)
        send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      send_req(txt[i], (i == txt.size() - 1) && !end_empty, 1'b0);
    end
    if (end_empty) send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  function automatic octet_q_t encode_cp(logic [ucd_pkg::CpW-1:0] cp, int unsigned len);
    octet_q_t q;
    case (len)
      1:       q = '{cp[7:0]};
      2:       q = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
      3:       q = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      default: q = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                     {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    endcase
    return q;
  endfunction

  // Mostly well-formed encodings of random code points per length class,
  // then overlong forms, out-of-range values and plain byte noise; some get
  // one byte corrupted, dropped or appended.
  function automatic octet_q_t random_text();
    octet_q_t                q;
    int unsigned             r;
    int unsigned             len;
    logic [ucd_pkg::CpW-1:0] cp;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      q = encode_cp(ucd_pkg::CpW'($urandom_range(0, 'h7F)), 1);
    end else if (r < 35) begin
      q = encode_cp(ucd_pkg::CpW'($urandom_range('h80, 'h7FF)), 2);
    end else if (r < 60) begin
      cp = ($urandom_range(0, 9) == 0) ? ucd_pkg::CpW'($urandom_range('hD800, 'hDFFF))
                                      : ucd_pkg::CpW'($urandom_range('h800, 'hFFFF));
      q = encode_cp(cp, 3);
    end else if (r < 80) begin
      q = encode_cp(ucd_pkg::CpW'($urandom_range('h10000, 'h10FFFF)), 4);
    end else if (r < 85) begin
      q = encode_cp(ucd_pkg::CpW'($urandom_range('h110000, 'h1FFFFF)), 4);
    end else if (r < 90) begin
      len = $urandom_range(2, 4);
      cp  = (len == 2) ? ucd_pkg::CpW'($urandom_range(0, 'h7F))
          : (len == 3) ? ucd_pkg::CpW'($urandom_range(0, 'h7FF))
          :              ucd_pkg::CpW'($urandom_range(0, 'hFFFF));
      q = encode_cp(cp, len);
    end else begin
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++) q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 2))
        0:       q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        1:       if (q.size() > 1) void'(q.pop_back());
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    return q;
  endfunction

  // Holds the sender until every queued verdict has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned phase;
    int unsigned waited;
    phase = 0;
    sb    = new;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty text, ignored empty, ASCII and zero first bytes, bad
    // leads, length classes at their bounds, overlong, surrogate, above the
    // top of the range, trailing bytes after ASCII, early end by empty.
    send_req(8'hA5, 1'b1, 1'b1);
    send_req(8'h5A, 1'b0, 1'b1);
    send_text('{8'h7F}, 1'b0, 1'b0);
    send_text('{8'h00}, 1'b0, 1'b0);
    send_text('{8'h80}, 1'b0, 1'b0);
    send_text('{8'hFF}, 1'b0, 1'b0);
    send_text('{8'hC2, 8'h80}, 1'b0, 1'b0);
    send_text('{8'hC1, 8'hBF}, 1'b0, 1'b0);
    send_text('{8'hED, 8'hA0, 8'h80}, 1'b0, 1'b0);
    send_text('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0, 1'b0);
    send_text('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0, 1'b0);
    send_text('{8'h41, 8'hC3}, 1'b0, 1'b0);
    send_text('{8'hE2, 8'h82}, 1'b1, 1'b0);

    // Random run in phases: both sides idling, sender at full rate,
    // receiver never stalling, then both at full rate. Each phase change
    // drains the pipe first.
    items_sent = 0;
    gap_on     = 1'b1;
    stall_on   = 1'b1;
    while (items_sent < NumItems) begin
      if (items_sent / PhaseLen != phase) begin
        phase = items_sent / PhaseLen;
        drain();
        gap_on   = (phase % 4 == 0) || (phase % 4 == 2);
        stall_on = (phase % 4 == 0) || (phase % 4 == 1);
      end
      if ($urandom_range(0, 99) < 3) send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      else send_text(random_text(), $urandom_range(0, 9) == 0, 1'b1);
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    // extra cycles to catch a result nobody asked for
    repeat (TailCycles) @(posedge clk_i);
    while (sb.pending() != 0) begin
      verdict_t lost;
      lost = sb.expected_q.pop_front();
      $display("%0t: expected ok=%0b cp=%06h, actual none", $time, lost.ok, lost.cp);
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
